// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on clk with an
// asynchronous active-low reset arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, controller states and control structs for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

	localparam int WIDTH = 31;               // modulus, base and result width
	localparam int EXP_W = 63;               // exponent field width
	localparam int CNT_W = $clog2(WIDTH);    // step counter width
	localparam logic [WIDTH-1:0] MODULUS_RESET = 31'd1000000007;
	localparam logic [WIDTH-1:0] FERMAT_OFFSET = 31'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SETSQ,
		ST_CHECK,
		ST_MULT,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture a new item, start base reduction
		logic step;       // one shift-add modular step on both lanes
		logic reduce;     // square lane adds 1 instead of sq (base reduction)
		logic set_sq;     // reduced base becomes the running square
		logic begin_mult; // clear lanes, scan bits of the running square
		logic update;     // commit product and square, shift exponent
		logic load_out;   // move the result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic small_mod;  // modulus below 2
		logic e_zero;     // no exponent bits left
		logic last_step;  // this step is the last of a product
	} status_t;

endpackage

`default_nettype wire

// ===== design/modular_exponentiation.sv =====
// Modular exponentiation, right-to-left square and multiply. Each item gives
// base_value, exponent and invert; one result item power_result =
// base_value ** exponent mod modulus follows. With invert set the exponent is
// modulus - 2 (Fermat inverse for a prime modulus). The base is first reduced
// with a 31-step shift-add pass, then each exponent bit costs one
// 31-step pass of the shared shift-add multiplier (square and conditional
// multiply run side by side in it) plus the CHECK and UPDATE bookkeeping
// states. The scan stops at the highest set exponent bit; a modulus below
// 2 gives 0 and skips the multiplier passes. The next item is taken once
// the current one has been moved into the output register. The modulus
// register (reset 1000000007) is written through the cfg channel; the user
// must write it only while the block is idle, which the block itself does
// not enforce. cfg_ready is always high.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Top level: controller plus datapath for base^exponent mod modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
	parameter int EXPONENT_BITS = 63    // exponent bits scanned, 1..63
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration: modulus
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [30:0] modulus,
	// input items
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [30:0] base_value,
	input  wire  [62:0] exponent,
	input  wire         invert,
	// result items
	output logic        out_valid,
	input  wire         out_stall,
	output logic [30:0] power_result
);

	mexp_pkg::cmd_t    cmd;
	mexp_pkg::status_t status;

	// register is always writable; the user writes it only while idle
	assign cfg_ready = 1'b1;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mexp_datapath #(
		.EXPONENT_BITS (EXPONENT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_modulus  (modulus),
		.base_value   (base_value),
		.exponent     (exponent),
		.invert       (invert),
		.cmd          (cmd),
		.status       (status),
		.power_result (power_result)
	);

endmodule

`default_nettype wire

// ===== design/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square and multiply; owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire                out_stall,
	input  mexp_pkg::status_t  status,
	output mexp_pkg::cmd_t     cmd
);

	mexp_pkg::state_t state_q, state_nxt;
	logic             out_valid_q;
	logic             out_free;
	logic             in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign in_take  = in_valid && (state_q == mexp_pkg::ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_valid)
					state_nxt = mexp_pkg::ST_REDUCE;
			end
			mexp_pkg::ST_REDUCE: begin
				if (status.small_mod)
					state_nxt = mexp_pkg::ST_FINISH;
				else if (status.last_step)
					state_nxt = mexp_pkg::ST_SETSQ;
			end
			mexp_pkg::ST_SETSQ:  state_nxt = mexp_pkg::ST_CHECK;
			mexp_pkg::ST_CHECK: begin
				state_nxt = status.e_zero ? mexp_pkg::ST_FINISH : mexp_pkg::ST_MULT;
			end
			mexp_pkg::ST_MULT: begin
				if (status.last_step)
					state_nxt = mexp_pkg::ST_UPDATE;
			end
			mexp_pkg::ST_UPDATE: state_nxt = mexp_pkg::ST_CHECK;
			mexp_pkg::ST_FINISH: begin
				if (out_free)
					state_nxt = mexp_pkg::ST_IDLE;
			end
			default: state_nxt = mexp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			mexp_pkg::ST_IDLE:   cmd.load = in_take;
			mexp_pkg::ST_REDUCE: begin
				cmd.step   = !status.small_mod;
				cmd.reduce = 1'b1;
			end
			mexp_pkg::ST_SETSQ:  cmd.set_sq = 1'b1;
			mexp_pkg::ST_CHECK:  cmd.begin_mult = !status.e_zero;
			mexp_pkg::ST_MULT:   cmd.step = 1'b1;
			mexp_pkg::ST_UPDATE: cmd.update = 1'b1;
			mexp_pkg::ST_FINISH: cmd.load_out = out_free;
			default:             cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != mexp_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== design/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath
// Modulus register, exponent shifter and two shift-add modular multiplier
// lanes that step together over the bits of the running square.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_datapath #(
	parameter int EXPONENT_BITS = 63
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [mexp_pkg::WIDTH-1:0]         cfg_modulus,
	input  wire  [mexp_pkg::WIDTH-1:0]         base_value,
	input  wire  [mexp_pkg::EXP_W-1:0]         exponent,
	input  wire                                invert,
	input  mexp_pkg::cmd_t                     cmd,
	output mexp_pkg::status_t                  status,
	output logic [mexp_pkg::WIDTH-1:0]         power_result
);

	localparam int W  = mexp_pkg::WIDTH;
	localparam int EW = mexp_pkg::EXP_W;
	localparam int CW = mexp_pkg::CNT_W;

	logic [W-1:0]             mod_q;
	logic [EXPONENT_BITS-1:0] e_q;
	logic [W-1:0]             acc_q, sq_q, rx_q, rs_q, b_q, result_q;
	logic [CW-1:0]            cnt_q;
	logic                     small_q;

	logic [EW-1:0]            e_full;
	logic [W-1:0]             a_s, rx_nxt, rs_nxt;

	// r <- (2r + bit*a) mod m, with r < m and a < m
	function automatic logic [W-1:0] mod_step(input logic [W-1:0] r,
		input logic [W-1:0] a, input logic b, input logic [W-1:0] m);
		logic [W:0] d;
		logic [W:0] t;
		d = {r, 1'b0};
		if (d >= {1'b0, m})
			d = d - {1'b0, m};
		t = d + {1'b0, (b ? a : '0)};
		if (t >= {1'b0, m})
			t = t - {1'b0, m};
		return t[W-1:0];
	endfunction

	assign e_full = invert ? EW'(mod_q - mexp_pkg::FERMAT_OFFSET) : exponent;
	assign a_s    = cmd.reduce ? W'(1) : sq_q;
	assign rx_nxt = mod_step(rx_q, acc_q, b_q[W-1], mod_q);
	assign rs_nxt = mod_step(rs_q, a_s, b_q[W-1], mod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mod_q <= mexp_pkg::MODULUS_RESET;
		else if (cfg_we)
			mod_q <= cfg_modulus;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q     <= e_full[EXPONENT_BITS-1:0];
			b_q     <= base_value;
			rs_q    <= '0;
			rx_q    <= '0;
			acc_q   <= W'(1);
			cnt_q   <= '0;
			small_q <= (mod_q < mexp_pkg::FERMAT_OFFSET);
		end else if (cmd.step) begin
			rx_q  <= rx_nxt;
			rs_q  <= rs_nxt;
			b_q   <= {b_q[W-2:0], 1'b0};
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.set_sq) begin
			sq_q <= rs_q;
		end else if (cmd.begin_mult) begin
			rx_q  <= '0;
			rs_q  <= '0;
			b_q   <= sq_q;
			cnt_q <= '0;
		end else if (cmd.update) begin
			if (e_q[0])
				acc_q <= rx_q;
			sq_q <= rs_q;
			e_q  <= e_q >> 1;
		end
		if (cmd.load_out)
			result_q <= small_q ? '0 : acc_q;
	end

	assign status.small_mod = small_q;
	assign status.e_zero    = (e_q == '0);
	assign status.last_step = (cnt_q == CW'(W - 1));
	assign power_result     = result_q;

endmodule

`default_nettype wire

// ===== design/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mexp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [30:0] power_result
);

	// a stalled result item stays put
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(power_result), "result item dropped or changed while stalled")

	// one item at a time: busy right after taking an item
	`ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken while an item is in work")

	// a freshly posted result frees the input side
	`ASSERT_SAME(a_ready_on_result, $rose(out_valid), !in_stall, "input still stalled after result posted")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.power_result (power_result)
);

`default_nettype wire

// ===== dv/modular_exponentiation_test.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Self-checking bench for the square-and-multiply power unit. A short
// stimulus table covers the corner cases. Random phases follow, one per
// modulus setting. Every result is compared with its known answer or a local power calculation.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_test;

	localparam int      WIDTH = mexp_pkg::WIDTH;
	localparam int      EXP_W = mexp_pkg::EXP_W;
	localparam int      HALF_PERIOD = 10;
	localparam int      RESET_CYCLES = 4;
	localparam int      PHASE_COUNT = 12;
	localparam int      PHASE_ITEMS = 160;
	localparam int      NARROW_ITEMS = 40;     // phase with modulus below 2
	localparam int      DRAIN_CYCLES = 2200;   // longer than one 63-bit item
	// The limit is far above the time the items need, even if every item
	// were a 63-bit one with the longest gaps and stalls on top.
	localparam longint  CYCLE_LIMIT = 20_000_000;
	localparam int      REPORT_MAX = 10;
	localparam int      DIR_ROWS = 25;
	localparam logic [EXP_W-1:0] EXP_ALL = '1;
	localparam logic [WIDTH-1:0] MOD_MAX = '1;

	// one row of the stimulus table
	typedef struct {
		logic             set_mod;   // write the modulus before this item
		logic [WIDTH-1:0] mod_val;
		logic [WIDTH-1:0] base;
		logic [EXP_W-1:0] expo;
		logic             inv;
		logic             typed;     // want holds the known answer
		logic [WIDTH-1:0] want;
	} vector_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [WIDTH-1:0] mod_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [WIDTH-1:0] base_drv = '0;
	logic [EXP_W-1:0] expo_drv = '0;
	logic             inv_drv = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [WIDTH-1:0] power_result;

	logic [WIDTH-1:0] cur_modulus = mexp_pkg::MODULUS_RESET;  // local copy of the register
	logic [WIDTH-1:0] power_due [$];                 // results still to arrive
	int               error_count = 0;
	longint           cycle_count = 0;
	bit               calm = 1'b0;                   // phase without any idling
	vector_row_t      dir_rows [DIR_ROWS];

	modular_exponentiation dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.modulus      (mod_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.base_value   (base_drv),
		.exponent     (expo_drv),
		.invert       (inv_drv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.power_result (power_result)
	);

	always #HALF_PERIOD clk = ~clk;

	// Run limit. A hang ends the run here.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Right-to-left square and multiply on 64-bit values. Both factors stay
	// below 2^31, so a product cannot overflow.
	function automatic logic [WIDTH-1:0] predict_power(input logic [WIDTH-1:0] m,
		input logic [WIDTH-1:0] b, input logic [EXP_W-1:0] e, input logic inv);
		logic [63:0]      acc;
		logic [63:0]      sq;
		logic [63:0]      mm;
		logic [EXP_W-1:0] ee;
		if (m < 2)
			return '0;
		mm = 64'(m);
		ee = inv ? EXP_W'(m - mexp_pkg::FERMAT_OFFSET) : e;
		acc = 64'd1;
		sq = 64'(b) % mm;
		for (int i = 0; i < EXP_W; i++) begin
			if (ee[i])
				acc = (acc * sq) % mm;
			sq = (sq * sq) % mm;
		end
		return acc[WIDTH-1:0];
	endfunction

	function automatic void note_error(input string what, input logic [WIDTH-1:0] want,
		input logic [WIDTH-1:0] got);
		error_count++;
		if (error_count <= REPORT_MAX)
			$display("[%0t] %s: power_result expected %0d, got %0d", $realtime, what,
				want, got);
	endfunction

	// Mostly back to back, sometimes short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver side: stall bursts of random length.
	initial begin : stall_gen
		int n;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			n = $urandom_range(1, 6);
			repeat (n) @(posedge clk);
		end
	end

	// Result check. Signals are sampled at the falling edge; a result seen
	// there with no stall moves at the next rising edge.
	always @(negedge clk) begin
		logic [WIDTH-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (power_due.size() == 0) begin
				note_error("result with nothing pending", '0, power_result);
			end else begin
				want = power_due.pop_front();
				if (power_result !== want)
					note_error("mismatch", want, power_result);
			end
		end
	end

	// Drive one item after a random gap. The task returns at the rising edge
	// that takes the item; in_valid stays high so the next item can follow
	// without a bubble.
	task automatic send_item(input logic [WIDTH-1:0] base, input logic [EXP_W-1:0] expo,
		input logic inv, input logic typed, input logic [WIDTH-1:0] want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		base_drv <= base;
		expo_drv <= expo;
		inv_drv <= inv;
		do @(negedge clk); while (in_stall);
		power_due.push_back(typed ? want : predict_power(cur_modulus, base, expo, inv));
		@(posedge clk);
	endtask

	// The register is written only once every pending result has arrived.
	task automatic write_modulus(input logic [WIDTH-1:0] value);
		while (power_due.size() != 0)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		mod_wr_data <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		cur_modulus = value;
	endtask

	// Modulus for each random phase: the defaults, the extremes and random
	// values of several sizes.
	function automatic logic [WIDTH-1:0] phase_modulus(input int p);
		case (p)
			0: return mexp_pkg::MODULUS_RESET;
			1: return MOD_MAX;
			2: return 31'd2;
			3: return 31'd3;
			4: return 31'd65537;
			5: return WIDTH'($urandom_range(2, 255));
			6: return WIDTH'($urandom_range(2, 32'h7FFF_FFFF));
			7: return WIDTH'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF) | 1);
			8: return WIDTH'($urandom_range(0, 1));
			9: return WIDTH'($urandom_range(2, 65535));
			10: return WIDTH'($urandom_range(2, 32'h7FFF_FFFF));
			default: return mexp_pkg::MODULUS_RESET;
		endcase
	endfunction

	function automatic logic [WIDTH-1:0] pick_base(input logic [WIDTH-1:0] m);
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return $urandom_range(0, 1) ? WIDTH'(1) : MOD_MAX;
			2: return (m == 0) ? '0 : WIDTH'(m * $urandom_range(0, MOD_MAX / m));
			3: return WIDTH'(m - 1);
			default: return WIDTH'($urandom());
		endcase
	endfunction

	// Most exponents are short; the cost grows with the highest set bit.
	function automatic logic [EXP_W-1:0] pick_exponent();
		int               r;
		int               w;
		logic [63:0]      raw;
		logic [EXP_W-1:0] mask;
		r = $urandom_range(0, 99);
		if (r < 75)
			w = $urandom_range(0, 10);
		else if (r < 95)
			w = $urandom_range(11, 32);
		else
			w = $urandom_range(33, EXP_W);
		if (w == 0)
			return '0;
		raw = {$urandom(), $urandom()};
		mask = EXP_ALL >> (EXP_W - w);
		return (raw[EXP_W-1:0] & mask) | (EXP_W'(1) << (w - 1));
	endfunction

	initial begin : main
		int               items;
		logic [WIDTH-1:0] m;
		logic [WIDTH-1:0] b;

		// set_mod, modulus, base, exponent, invert, typed, known answer
		dir_rows = '{
			// modulus from reset
			'{1'b0, 31'd0, 31'd0, 63'd0, 1'b0, 1'b1, 31'd1},
			'{1'b0, 31'd0, MOD_MAX, 63'd0, 1'b0, 1'b1, 31'd1},
			'{1'b0, 31'd0, 31'd0, 63'd5, 1'b0, 1'b1, 31'd0},
			'{1'b0, 31'd0, 31'd1, EXP_ALL, 1'b0, 1'b1, 31'd1},
			'{1'b0, 31'd0, 31'd2, 63'd10, 1'b0, 1'b1, 31'd1024},
			'{1'b0, 31'd0, 31'd1000000007, 63'd3, 1'b0, 1'b1, 31'd0},
			// base a multiple of the modulus, inverted
			'{1'b0, 31'd0, 31'd1000000007, 63'd0, 1'b1, 1'b1, 31'd0},
			'{1'b0, 31'd0, 31'd2000000014, 63'd0, 1'b1, 1'b1, 31'd0},
			'{1'b0, 31'd0, 31'd2, 63'd0, 1'b1, 1'b0, 31'd0},
			'{1'b0, 31'd0, MOD_MAX, EXP_ALL, 1'b0, 1'b0, 31'd0},
			'{1'b0, 31'd0, 31'd1000000008, 63'd1, 1'b0, 1'b1, 31'd1},
			// exponent ignored under invert
			'{1'b0, 31'd0, 31'd12345, EXP_ALL, 1'b1, 1'b0, 31'd0},
			// modulus 2: inverse exponent is 0
			'{1'b1, 31'd2, 31'd0, 63'd0, 1'b1, 1'b1, 31'd1},
			'{1'b0, 31'd0, MOD_MAX, EXP_ALL, 1'b0, 1'b1, 31'd1},
			'{1'b0, 31'd0, 31'd4, 63'd1, 1'b0, 1'b1, 31'd0},
			// modulus below 2 always gives 0
			'{1'b1, 31'd0, 31'd5, 63'd3, 1'b0, 1'b1, 31'd0},
			'{1'b0, 31'd0, 31'd0, 63'd0, 1'b1, 1'b1, 31'd0},
			'{1'b1, 31'd1, 31'd5, 63'd0, 1'b0, 1'b1, 31'd0},
			// largest modulus, base -1 and 0 modulo it
			'{1'b1, MOD_MAX, MOD_MAX, 63'd0, 1'b0, 1'b1, 31'd1},
			'{1'b0, 31'd0, MOD_MAX, 63'd9, 1'b1, 1'b1, 31'd0},
			'{1'b0, 31'd0, MOD_MAX - 31'd1, 63'd2, 1'b0, 1'b1, 31'd1},
			'{1'b0, 31'd0, MOD_MAX - 31'd1, 63'd0, 1'b1, 1'b1, MOD_MAX - 31'd1},
			'{1'b0, 31'd0, MOD_MAX - 31'd1, EXP_ALL, 1'b0, 1'b1, MOD_MAX - 31'd1},
			// modulus 3: inverse exponent 1
			'{1'b1, 31'd3, 31'd2, 63'd0, 1'b1, 1'b1, 31'd2},
			'{1'b0, 31'd0, 31'd5, 63'h5555_5555_5555_5555, 1'b0, 1'b0, 31'd0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_mod) begin
				in_valid <= 1'b0;
				write_modulus(dir_rows[i].mod_val);
			end
			send_item(dir_rows[i].base, dir_rows[i].expo, dir_rows[i].inv,
				dir_rows[i].typed, dir_rows[i].want);
		end
		in_valid <= 1'b0;

		// random phases, one modulus each; some phases without any idling
		for (int p = 0; p < PHASE_COUNT; p++) begin
			m = phase_modulus(p);
			write_modulus(m);
			calm = ($urandom_range(0, 3) == 0);
			items = (p == 8) ? NARROW_ITEMS : PHASE_ITEMS;
			for (int k = 0; k < items; k++) begin
				b = pick_base(m);
				send_item(b, pick_exponent(), ($urandom_range(0, 9) == 0), 1'b0, '0);
			end
			in_valid <= 1'b0;
		end
		calm = 1'b0;

		while (power_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
